[rtl/clipped_keyed_blitter_defines.svh]
// -----------------------------------------------------------------------------
// Clipped keyed blitter assertion macros
// Concurrent assertion helpers used by the blitter RTL.
// -----------------------------------------------------------------------------
`ifndef CLIPPED_KEYED_BLITTER_DEFINES_SVH
`define CLIPPED_KEYED_BLITTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define CKB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle leads to another in the next.
`define CKB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CKB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CKB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/ckb_pkg.sv]
// -----------------------------------------------------------------------------
// Clipped keyed blitter package
// Field widths, operation and mode codes, register indexes and reset values.
// -----------------------------------------------------------------------------
package ckb_pkg;

	localparam int POS_W    = 16;
	localparam int SIZE_W   = 12;
	localparam int COLOR_W  = 8;
	localparam int CLIP_X_W = 10;
	localparam int CLIP_Y_W = 9;
	localparam int STRIDE_W = 13;
	localparam int ADDR_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_FILL  = 2'd0,
		MODE_COPY  = 2'd1,
		MODE_KEY   = 2'd2,
		MODE_GLYPH = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_TOP    = 3'd1,
		REG_CLIP_RIGHT  = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_LINE_STRIDE = 3'd4,
		REG_FRAME_BASE  = 3'd5
	} cfg_reg_t;

	localparam logic [CLIP_X_W-1:0] CLIP_LEFT_RST   = 10'd0;
	localparam logic [CLIP_Y_W-1:0] CLIP_TOP_RST    = 9'd0;
	localparam logic [CLIP_X_W-1:0] CLIP_RIGHT_RST  = 10'd640;
	localparam logic [CLIP_Y_W-1:0] CLIP_BOTTOM_RST = 9'd480;
	localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 13'd640;
	localparam logic [ADDR_W-1:0]   FRAME_BASE_RST  = 32'd0;

endpackage

[rtl/clipped_keyed_blitter.sv]
// A pixel item passes through the input register and then the result register
// before it drives the outputs.
// Throughput: one item per cycle; the input register frees whenever the result
// register is empty or taken, so stall on the output side is the only limit.
// Begin items and pixels with no open rectangle give no result.
// Reset (arst_n low) clears both stages, closes any rectangle, restores the clip.
// -----------------------------------------------------------------------------
// Clipped keyed blitter
// Walks a rectangle in raster order and emits one clipped, keyed frame buffer
// write per pixel item of an open rectangle.
// -----------------------------------------------------------------------------
`include "clipped_keyed_blitter_defines.svh"

module clipped_keyed_blitter
	import ckb_pkg::*;
#(
	parameter int SCREEN_W = 640,
	parameter int SCREEN_H = 480,
	parameter int DIM_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [SIZE_W-1:0]       rect_w,
	input  logic [SIZE_W-1:0]       rect_h,
	input  logic [1:0]              mode,
	input  logic [COLOR_W-1:0]      color,
	input  logic [COLOR_W-1:0]      pixel,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    write_en,
	output logic [ADDR_W-1:0]       write_addr,
	output logic [COLOR_W-1:0]      write_data,
	output logic                    rect_done
);

	// signed width that holds origin plus cursor without overflow
	localparam int XW = (DIM_BITS + 2 > POS_W + 1) ? DIM_BITS + 2 : POS_W + 1;

	// configuration registers
	logic [CLIP_X_W-1:0] clip_left_q, clip_right_q;
	logic [CLIP_Y_W-1:0] clip_top_q, clip_bottom_q;
	logic [STRIDE_W-1:0] line_stride_q;
	logic [ADDR_W-1:0]   frame_base_q;

	// rectangle state
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [DIM_BITS-1:0]     box_w_q, box_h_q, cursor_x_q, cursor_y_q;
	mode_t                   draw_mode_q;
	logic [COLOR_W-1:0]      draw_color_q;
	logic                    busy_q;

	// input stage
	logic                    valid_s1;
	op_t                     op_s1;
	logic signed [POS_W-1:0] pos_x_s1, pos_y_s1;
	logic [SIZE_W-1:0]       rect_w_s1, rect_h_s1;
	mode_t                   mode_s1;
	logic [COLOR_W-1:0]      color_s1, pixel_s1;

	// result stage
	logic                    valid_s2;
	logic                    wen_s2;
	logic [ADDR_W-1:0]       addr_s2;
	logic [COLOR_W-1:0]      data_s2;
	logic                    done_s2;

	logic adv_s1, load_s1, res_c;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;
	assign res_c    = adv_s1 && (op_s1 == OP_PIXEL) && busy_q;

	// ---------------------------------------------------------------- datapath
	logic signed [XW-1:0] x_c, y_c;
	logic signed [XW-1:0] left_c, top_c, right_c, bottom_c;
	logic                 inside_c, en_c, done_c, row_end_c;
	logic [COLOR_W-1:0]   data_c;
	logic [ADDR_W-1:0]    addr_c;
	logic [CLIP_Y_W+STRIDE_W-1:0] row_off_c;
	logic [DIM_BITS:0]    cx_inc_c, cy_inc_c;
	logic [SIZE_W+DIM_BITS-1:0]   box_w_ext_c, box_h_ext_c;

	always_comb begin
		x_c = XW'(origin_x_q) + XW'($signed({1'b0, cursor_x_q}));
		y_c = XW'(origin_y_q) + XW'($signed({1'b0, cursor_y_q}));

		left_c = $signed(XW'(clip_left_q));
		top_c  = $signed(XW'(clip_top_q));
		// the window never reaches past the screen
		if (int'(clip_right_q) > SCREEN_W) begin
			right_c = $signed(XW'(SCREEN_W));
		end else begin
			right_c = $signed(XW'(clip_right_q));
		end
		if (int'(clip_bottom_q) > SCREEN_H) begin
			bottom_c = $signed(XW'(SCREEN_H));
		end else begin
			bottom_c = $signed(XW'(clip_bottom_q));
		end
		inside_c = (x_c >= left_c) && (x_c < right_c) && (y_c >= top_c) && (y_c < bottom_c);

		case (draw_mode_q)
			MODE_FILL: begin
				en_c   = 1'b1;
				data_c = draw_color_q;
			end
			MODE_COPY: begin
				en_c   = 1'b1;
				data_c = pixel_s1;
			end
			MODE_KEY: begin
				en_c   = (pixel_s1 != draw_color_q);
				data_c = pixel_s1;
			end
			default: begin
				en_c   = pixel_s1[0];
				data_c = draw_color_q;
			end
		endcase
		en_c = en_c && inside_c;

		// inside the window x and y fit the clip register widths
		row_off_c = y_c[CLIP_Y_W-1:0] * line_stride_q;
		addr_c = frame_base_q + ADDR_W'(row_off_c) + ADDR_W'(x_c[CLIP_X_W-1:0]);
		if (!en_c) begin
			addr_c = '0;
			data_c = '0;
		end

		cx_inc_c  = {1'b0, cursor_x_q} + (DIM_BITS+1)'(1);
		cy_inc_c  = {1'b0, cursor_y_q} + (DIM_BITS+1)'(1);
		row_end_c = cx_inc_c >= {1'b0, box_w_q};
		done_c    = row_end_c && (cy_inc_c >= {1'b0, box_h_q});

		box_w_ext_c = {DIM_BITS'(0), rect_w_s1};
		box_h_ext_c = {DIM_BITS'(0), rect_h_s1};
	end

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= CLIP_LEFT_RST;
			clip_top_q    <= CLIP_TOP_RST;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
			line_stride_q <= LINE_STRIDE_RST;
			frame_base_q  <= FRAME_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CLIP_LEFT:   clip_left_q   <= cfg_data[CLIP_X_W-1:0];
				REG_CLIP_TOP:    clip_top_q    <= cfg_data[CLIP_Y_W-1:0];
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_data[CLIP_X_W-1:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[CLIP_Y_W-1:0];
				REG_LINE_STRIDE: line_stride_q <= cfg_data[STRIDE_W-1:0];
				REG_FRAME_BASE:  frame_base_q  <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			box_w_q      <= '0;
			box_h_q      <= '0;
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			draw_mode_q  <= MODE_FILL;
			draw_color_q <= '0;
			busy_q       <= 1'b0;
		end else if (adv_s1) begin
			if (op_s1 == OP_BEGIN) begin
				// open a new rectangle, abandoning any open one
				origin_x_q   <= pos_x_s1;
				origin_y_q   <= pos_y_s1;
				box_w_q      <= box_w_ext_c[DIM_BITS-1:0];
				box_h_q      <= box_h_ext_c[DIM_BITS-1:0];
				draw_mode_q  <= mode_s1;
				draw_color_q <= color_s1;
				cursor_x_q   <= '0;
				cursor_y_q   <= '0;
				busy_q       <= (box_w_ext_c[DIM_BITS-1:0] != '0) &&
				                (box_h_ext_c[DIM_BITS-1:0] != '0);
			end else if (busy_q) begin
				if (done_c) begin
					busy_q     <= 1'b0;
					cursor_x_q <= '0;
					cursor_y_q <= '0;
				end else if (row_end_c) begin
					cursor_x_q <= '0;
					cursor_y_q <= cy_inc_c[DIM_BITS-1:0];
				end else begin
					cursor_x_q <= cx_inc_c[DIM_BITS-1:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			// hold a stalled result, else take whatever the input stage produces
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= res_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1     <= op_t'(op);
			pos_x_s1  <= pos_x;
			pos_y_s1  <= pos_y;
			rect_w_s1 <= rect_w;
			rect_h_s1 <= rect_h;
			mode_s1   <= mode_t'(mode);
			color_s1  <= color;
			pixel_s1  <= pixel;
		end
		if (res_c) begin
			wen_s2  <= en_c;
			addr_s2 <= addr_c;
			data_s2 <= data_c;
			done_s2 <= done_c;
		end
	end

	assign out_valid  = valid_s2;
	assign write_en   = wen_s2;
	assign write_addr = addr_s2;
	assign write_data = data_s2;
	assign rect_done  = done_s2;

	// ---------------------------------------------------------------- checks
	`CKB_ASSERT(a_cursor_in_box, clk, arst_n, !busy_q || ((cursor_x_q < box_w_q) && (cursor_y_q < box_h_q)), "cursor left the open rectangle")
	`CKB_ASSERT(a_idle_cursor_zero, clk, arst_n, busy_q || ((cursor_x_q == '0) && (cursor_y_q == '0)), "cursor not parked while no rectangle is open")
	`CKB_ASSERT(a_skip_zero, clk, arst_n, !(valid_s2 && !wen_s2) || ((addr_s2 == '0) && (data_s2 == '0)), "skipped pixel carries address or data")
	`CKB_ASSERT_NEXT(a_done_closes, clk, arst_n, res_c && done_c, !busy_q && valid_s2 && done_s2, "last pixel did not close the rectangle")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Clipped keyed blitter testbench
// Sends begin and pixel items and idles both sides of the stream. A local
// model of the blitter predicts every frame buffer write, and each result is
// compared with the oldest prediction. Covers all modes, abandoned and empty
// rectangles, stray pixels, and many clip, stride and base settings.
// -----------------------------------------------------------------------------
module testbench;
	import ckb_pkg::*;

	localparam int SCREEN_W = 640;
	localparam int SCREEN_H = 480;
	localparam int DIM_BITS = 12;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		op_t                     op;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [SIZE_W-1:0]       w;
		logic [SIZE_W-1:0]       h;
		mode_t                   md;
		logic [COLOR_W-1:0]      col;
		logic [COLOR_W-1:0]      pix;
	} blit_item_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] data;
		logic               done;
	} blit_write_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_CLIP_LEFT;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    op = OP_BEGIN;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic [SIZE_W-1:0]       rect_w = '0;
	logic [SIZE_W-1:0]       rect_h = '0;
	logic [1:0]              mode = MODE_FILL;
	logic [COLOR_W-1:0]      color = '0;
	logic [COLOR_W-1:0]      pixel = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    write_en;
	logic [ADDR_W-1:0]       write_addr;
	logic [COLOR_W-1:0]      write_data;
	logic                    rect_done;

	// model state: registers and the open rectangle
	logic [CLIP_X_W-1:0]     clip_l_q = CLIP_LEFT_RST;
	logic [CLIP_Y_W-1:0]     clip_t_q = CLIP_TOP_RST;
	logic [CLIP_X_W-1:0]     clip_r_q = CLIP_RIGHT_RST;
	logic [CLIP_Y_W-1:0]     clip_b_q = CLIP_BOTTOM_RST;
	logic [STRIDE_W-1:0]     stride_q = LINE_STRIDE_RST;
	logic [ADDR_W-1:0]       base_q = FRAME_BASE_RST;
	logic signed [POS_W-1:0] org_x = '0;
	logic signed [POS_W-1:0] org_y = '0;
	logic [SIZE_W-1:0]       box_w = '0;
	logic [SIZE_W-1:0]       box_h = '0;
	logic [SIZE_W-1:0]       cur_x = '0;
	logic [SIZE_W-1:0]       cur_y = '0;
	mode_t                   draw_mode = MODE_FILL;
	logic [COLOR_W-1:0]      draw_color = '0;
	bit                      rect_open = 1'b0;

	blit_write_t pending_writes[$];
	int          accepted_items = 0;
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	clipped_keyed_blitter #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H),
		.DIM_BITS(DIM_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.mode(mode),
		.color(color),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_en(write_en),
		.write_addr(write_addr),
		.write_data(write_data),
		.rect_done(rect_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Outputs and our stall are stable at the falling edge; a result seen here
	// is taken at the next rising edge.
	always @(negedge clk) begin : check_writes
		blit_write_t got;
		blit_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{write_en, write_addr, write_data, rect_done};
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write: en=%0b addr=%h data=%h done=%0b",
					$time, got.en, got.addr, got.data, got.done);
				mismatch_count++;
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					$display("%0t: expected %0b/%h/%h/%0b, actual %0b/%h/%h/%0b", $time,
						want.en, want.addr, want.data, want.done,
						got.en, got.addr, got.data, got.done);
					mismatch_count++;
				end
			end
		end
	end

	task automatic predict_write(input blit_item_t it);
		int x, y, right, bottom;
		blit_write_t w;
		bit end_x, end_y;
		if (it.op == OP_BEGIN) begin
			org_x = it.px;
			org_y = it.py;
			box_w = it.w;
			box_h = it.h;
			draw_mode = it.md;
			draw_color = it.col;
			cur_x = '0;
			cur_y = '0;
			rect_open = (it.w != 0) && (it.h != 0);
			return;
		end
		if (!rect_open)
			return;
		x = int'(org_x) + int'(cur_x);
		y = int'(org_y) + int'(cur_y);
		right = (int'(clip_r_q) > SCREEN_W) ? SCREEN_W : int'(clip_r_q);
		bottom = (int'(clip_b_q) > SCREEN_H) ? SCREEN_H : int'(clip_b_q);
		w = '0;
		if (x >= int'(clip_l_q) && x < right && y >= int'(clip_t_q) && y < bottom) begin
			case (draw_mode)
				MODE_FILL: begin
					w.en = 1'b1;
					w.data = draw_color;
				end
				MODE_COPY: begin
					w.en = 1'b1;
					w.data = it.pix;
				end
				MODE_KEY: begin
					w.en = (it.pix != draw_color);
					w.data = it.pix;
				end
				default: begin
					w.en = it.pix[0];
					w.data = draw_color;
				end
			endcase
			if (w.en)
				w.addr = base_q + ADDR_W'(y) * ADDR_W'(stride_q) + ADDR_W'(x);
			else
				w.data = '0;
		end
		end_x = (int'(cur_x) + 1 >= int'(box_w));
		end_y = (int'(cur_y) + 1 >= int'(box_h));
		w.done = end_x && end_y;
		if (w.done) begin
			rect_open = 1'b0;
			cur_x = '0;
			cur_y = '0;
		end else if (end_x) begin
			cur_x = '0;
			cur_y = cur_y + 1'b1;
		end else begin
			cur_x = cur_x + 1'b1;
		end
		pending_writes.push_back(w);
	endtask

	function automatic blit_item_t random_item();
		blit_item_t it;
		it.op = op_t'($urandom_range(0, 1));
		it.px = POS_W'($urandom);
		it.py = POS_W'($urandom);
		it.w = SIZE_W'($urandom);
		it.h = SIZE_W'($urandom);
		it.md = mode_t'($urandom_range(0, 3));
		it.col = COLOR_W'($urandom);
		it.pix = COLOR_W'($urandom);
		return it;
	endfunction

	function automatic blit_item_t begin_item(int x, int y, int w, int h, mode_t md,
		logic [COLOR_W-1:0] col);
		blit_item_t it;
		it = random_item();
		it.op = OP_BEGIN;
		it.px = POS_W'(x);
		it.py = POS_W'(y);
		it.w = SIZE_W'(w);
		it.h = SIZE_W'(h);
		it.md = md;
		it.col = col;
		return it;
	endfunction

	function automatic blit_item_t pixel_item(logic [COLOR_W-1:0] value);
		blit_item_t it;
		it = random_item();
		it.op = OP_PIXEL;
		it.pix = value;
		return it;
	endfunction

	// Called at a rising edge; returns at the edge that accepted the item,
	// with valid still high.
	task automatic send_item(input blit_item_t it);
		bit stalled;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		pos_x <= it.px;
		pos_y <= it.py;
		rect_w <= it.w;
		rect_h <= it.h;
		mode <= it.md;
		color <= it.col;
		pixel <= it.pix;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		if (it.op == OP_BEGIN || rect_open)
			accepted_items++;
		predict_write(it);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_CLIP_LEFT:   clip_l_q = value[CLIP_X_W-1:0];
			REG_CLIP_TOP:    clip_t_q = value[CLIP_Y_W-1:0];
			REG_CLIP_RIGHT:  clip_r_q = value[CLIP_X_W-1:0];
			REG_CLIP_BOTTOM: clip_b_q = value[CLIP_Y_W-1:0];
			REG_LINE_STRIDE: stride_q = value[STRIDE_W-1:0];
			REG_FRAME_BASE:  base_q = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_clip_setting(int l, int t, int r, int b, int stride,
		logic [ADDR_W-1:0] base);
		wait_results_done();
		write_reg(REG_CLIP_LEFT, CFG_DATA_W'(l));
		write_reg(REG_CLIP_TOP, CFG_DATA_W'(t));
		write_reg(REG_CLIP_RIGHT, CFG_DATA_W'(r));
		write_reg(REG_CLIP_BOTTOM, CFG_DATA_W'(b));
		write_reg(REG_LINE_STRIDE, CFG_DATA_W'(stride));
		write_reg(REG_FRAME_BASE, base);
	endtask

	task automatic send_random_rect();
		blit_item_t it, px;
		int choice, npix, nx, ny;
		it = begin_item(0, 0, 1, 1, mode_t'($urandom_range(0, 3)), COLOR_W'($urandom));
		choice = $urandom_range(0, 99);
		if (choice < 6) begin
			// huge rectangle: walk a few positions, then abandon it
			it.w = SIZE_W'($urandom);
			it.h = SIZE_W'($urandom);
			npix = $urandom_range(0, 6);
		end else if (choice < 11) begin
			it.w = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom);
			it.h = (it.w == 0) ? SIZE_W'($urandom) : '0;
			npix = $urandom_range(0, 2);
		end else begin
			it.w = SIZE_W'($urandom_range(1, 8));
			it.h = SIZE_W'($urandom_range(1, 6));
			npix = int'(it.w) * int'(it.h);
			if ($urandom_range(0, 9) == 0)
				npix = $urandom_range(0, npix - 1);
		end
		choice = $urandom_range(0, 99);
		if (choice < 50) begin
			// straddle an edge of the clip window
			nx = ($urandom_range(0, 1) ? int'(clip_l_q) : int'(clip_r_q) - int'(it.w))
				+ int'($urandom_range(0, 8)) - 4;
			ny = ($urandom_range(0, 1) ? int'(clip_t_q) : int'(clip_b_q) - int'(it.h))
				+ int'($urandom_range(0, 8)) - 4;
		end else if (choice < 85) begin
			nx = int'($urandom_range(0, 680)) - 20;
			ny = int'($urandom_range(0, 520)) - 20;
		end else begin
			nx = $urandom;
			ny = $urandom;
		end
		it.px = POS_W'(nx);
		it.py = POS_W'(ny);
		send_item(it);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 49) == 0)
				wait_results_done();
			px = pixel_item(COLOR_W'($urandom));
			if (it.md == MODE_KEY && $urandom_range(0, 2) == 0)
				px.pix = it.col;
			send_item(px);
		end
		// stray pixels land after the rectangle closed or was left open
		if ($urandom_range(0, 11) == 0)
			repeat ($urandom_range(1, 2)) send_item(pixel_item(COLOR_W'($urandom)));
	endtask

	task automatic run_traffic(int n_items);
		int target, next_cfg, choice, l, t, r, b, stride;
		target = accepted_items + n_items;
		next_cfg = accepted_items + $urandom_range(60, 100);
		while (accepted_items < target) begin
			if (accepted_items >= next_cfg) begin
				choice = $urandom_range(0, 99);
				if (choice < 70) begin
					l = $urandom_range(0, 600);
					t = $urandom_range(0, 450);
					r = l + int'($urandom_range(0, 80));
					b = t + int'($urandom_range(0, 60));
				end else if (choice < 85) begin
					l = 0;
					t = 0;
					r = SCREEN_W;
					b = SCREEN_H;
				end else begin
					l = $urandom_range(0, 1023);
					t = $urandom_range(0, 511);
					r = $urandom_range(0, 1023);
					b = $urandom_range(0, 511);
				end
				case ($urandom_range(0, 3))
					0: stride = $urandom_range(0, 8191);
					1: stride = $urandom_range(1, 4096);
					2: stride = SCREEN_W;
					default: stride = $urandom_range(1, 64);
				endcase
				apply_clip_setting(l, t, r, b, stride, ADDR_W'($urandom));
				next_cfg = accepted_items + $urandom_range(60, 100);
			end
			send_random_rect();
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		// nothing open after reset: ignored
		send_item(pixel_item(8'h5A));
		send_item(begin_item(0, 0, 2, 1, MODE_FILL, 8'hFF));
		send_item(pixel_item(8'h00));
		send_item(pixel_item(8'hFF));
		// crosses the right and bottom screen edges
		send_item(begin_item(638, 479, 3, 2, MODE_COPY, 8'h00));
		for (int i = 0; i < 6; i++) begin
			if (i == 3)
				wait_results_done();
			send_item(pixel_item(COLOR_W'(i * 8'h33)));
		end
		send_item(begin_item(10, 10, 2, 1, MODE_KEY, 8'h3C));
		send_item(pixel_item(8'h3C));
		send_item(pixel_item(8'hC3));
		// abandon a large open rectangle with the next begin
		send_item(begin_item(600, 0, 4095, 4095, MODE_FILL, 8'h42));
		send_item(pixel_item(8'h00));
		send_item(pixel_item(8'hFF));
		send_item(begin_item(-32768, 32767, 4095, 4095, MODE_GLYPH, 8'h80));
		send_item(pixel_item(8'h01));
		send_item(begin_item(32767, -32768, 0, 5, MODE_GLYPH, 8'h7F));
		send_item(pixel_item(8'h01));
		send_item(begin_item(20, 20, 1, 2, MODE_GLYPH, 8'hFF));
		send_item(pixel_item(8'hFE));
		send_item(pixel_item(8'h01));
		send_item(begin_item(5, 5, 5, 0, MODE_COPY, 8'h00));
		send_item(pixel_item(8'h11));
	endtask

	task automatic test_clip_settings();
		send_idle_pct = 21;
		stall_pct = 21;
		apply_clip_setting(1023, 511, 1023, 511, 8191, 32'hFFFF_FFFF);
		repeat (4) send_random_rect();
		apply_clip_setting(0, 0, 1023, 511, 0, 32'hFFFF_FFF0);
		repeat (4) send_random_rect();
		apply_clip_setting(100, 50, 100, 60, 1, 32'h0000_0000);
		repeat (4) send_random_rect();
		apply_clip_setting(5, 5, 6, 6, 1, 32'h8000_0000);
		repeat (6) send_random_rect();
		apply_clip_setting(639, 479, 640, 480, 4096, 32'hDEAD_BEEF);
		repeat (6) send_random_rect();
		apply_clip_setting(0, 0, SCREEN_W, SCREEN_H, SCREEN_W, 32'h0000_0000);
		repeat (4) send_random_rect();
	endtask

	task automatic test_steady_stream();
		send_idle_pct = 0;
		stall_pct = 0;
		run_traffic(160);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 80;
		stall_pct = 0;
		run_traffic(160);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		stall_pct = 80;
		run_traffic(160);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 21;
		stall_pct = 21;
		run_traffic(160);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clip_settings();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		wait_results_done();
		stall_pct = 0;
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/ckb_pkg.sv
rtl/clipped_keyed_blitter.sv
sim/testbench.sv
